@@ rtl/ray_plane_rect_hit_test_defines.svh @@
// Assertion macros for the checker file rphit_chk.sv.
`ifndef RAY_PLANE_RECT_HIT_TEST_DEFINES_SVH
`define RAY_PLANE_RECT_HIT_TEST_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define RPHIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rphit assertion failed");

// Next-cycle implication, muted during reset.
`define RPHIT_ASSERT_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rphit assertion failed");

// Next-cycle implication that also holds through reset.
`define RPHIT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rphit assertion failed");

`endif

@@ rtl/rphit_pkg.sv @@
`default_nettype none
package rphit_pkg;

    localparam int COORD_W    = 32;
    localparam int NORM_W     = 18;
    localparam int DIST_W     = 31;
    localparam int PROD_W     = 50;
    localparam int NUM_W      = 54;
    localparam int DEN_W      = 52;
    localparam int MAG_W      = 53;
    localparam int X_W        = 70;
    localparam int Q_W        = 32;
    localparam int XH_W       = X_W - Q_W;
    localparam int FRAC_W     = 16;
    localparam int DIV_BITS   = 2;
    localparam int EXT_W      = 33;
    localparam int EPROD_W    = 65;
    localparam int FQ_W       = 50;
    localparam int CMP_W      = FQ_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 224;
    localparam int M_TDATA_W  = 160;

    // 0.01 in Q16.16
    localparam logic [Q_W-1:0] EPS_Q16 = 32'd655;
    localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [NORM_W-1:0] NY_RESET = 18'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X     = 4'd0,
        REG_NORMAL_Y     = 4'd1,
        REG_NORMAL_Z     = 4'd2,
        REG_PLANE_OFFSET = 4'd3,
        REG_CORNER_A_X   = 4'd4,
        REG_CORNER_A_Z   = 4'd5,
        REG_CORNER_C_X   = 4'd6,
        REG_CORNER_C_Z   = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic signed [COORD_W-1:0] off;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cz;
    } cfg_t;

    // Item context carried down the pipe
    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dz;
        logic [DIST_W-1:0]         best;
        logic                      t_neg;
        logic                      num_pos;
        logic                      num_zero;
        logic                      h_neg;
        logic                      ny_zero;
    } ctx_t;

    // Divider working state
    typedef struct packed {
        logic             ovf;
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   xl;
        logic [Q_W-1:0]   q;
        logic [DEN_W-1:0] d;
    } div_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
        logic signed [COORD_W-1:0] hz;
        logic [DIST_W-1:0]         best;
        logic signed [COORD_W-1:0] height;
    } res_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [FQ_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > FQ_W'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < FQ_W'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rphit_cfg.sv @@
`default_nettype none
module rphit_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_en,
    input  wire logic [rphit_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [rphit_pkg::CFG_DATA_W-1:0] wr_data,
    output rphit_pkg::cfg_t                      cfg
);
    import rphit_pkg::*;

    cfg_t cfg_reg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{nx: '0, ny: NY_RESET, nz: '0, off: '0,
                         ax: '0, az: '0, cx: '0, cz: '0};
        end else if (wr_en) begin
            unique case (reg_idx_t'(wr_index))
                REG_NORMAL_X:     cfg_reg.nx  <= wr_data[NORM_W-1:0];
                REG_NORMAL_Y:     cfg_reg.ny  <= wr_data[NORM_W-1:0];
                REG_NORMAL_Z:     cfg_reg.nz  <= wr_data[NORM_W-1:0];
                REG_PLANE_OFFSET: cfg_reg.off <= wr_data;
                REG_CORNER_A_X:   cfg_reg.ax  <= wr_data;
                REG_CORNER_A_Z:   cfg_reg.az  <= wr_data;
                REG_CORNER_C_X:   cfg_reg.cx  <= wr_data;
                REG_CORNER_C_Z:   cfg_reg.cz  <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ rtl/rphit_front.sv @@
`default_nettype none
module rphit_front (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  rphit_pkg::cfg_t cfg,
    input  rphit_pkg::ctx_t in_ctx,
    output logic            out_valid,
    output rphit_pkg::ctx_t out_ctx,
    output rphit_pkg::div_t out_div
);
    import rphit_pkg::*;

    // stage 1: products
    logic v1_reg;
    ctx_t ctx1_reg;
    logic signed [PROD_W-1:0] pxnx_reg, pyny_reg, pznz_reg, dxnx_reg, dyny_reg, dznz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx1_reg <= in_ctx;
            pxnx_reg <= PROD_W'(in_ctx.px) * PROD_W'(cfg.nx);
            pyny_reg <= PROD_W'(in_ctx.py) * PROD_W'(cfg.ny);
            pznz_reg <= PROD_W'(in_ctx.pz) * PROD_W'(cfg.nz);
            dxnx_reg <= PROD_W'(in_ctx.dx) * PROD_W'(cfg.nx);
            dyny_reg <= PROD_W'(in_ctx.dy) * PROD_W'(cfg.ny);
            dznz_reg <= PROD_W'(in_ctx.dz) * PROD_W'(cfg.nz);
        end
    end

    // stage 2: dot products, numerator and denominator select
    logic signed [NUM_W-1:0] off_s, pn_xz, snum, hnum, num2_next;
    logic signed [DEN_W-1:0] t_sum, den2_next;
    ctx_t ctx2_next;

    always_comb begin
        off_s  = NUM_W'(cfg.off) <<< FRAC_W;
        pn_xz  = NUM_W'(pxnx_reg) + NUM_W'(pznz_reg);
        snum   = off_s - pn_xz - NUM_W'(pyny_reg);
        hnum   = pn_xz - off_s;
        t_sum  = DEN_W'(dxnx_reg) + DEN_W'(dyny_reg) + DEN_W'(dznz_reg);
        num2_next = ctx1_reg.cmd ? hnum : snum;
        den2_next = ctx1_reg.cmd ? DEN_W'(cfg.ny) : t_sum;
        ctx2_next          = ctx1_reg;
        ctx2_next.t_neg    = t_sum[DEN_W-1];
        ctx2_next.num_pos  = (num2_next > 0);
        ctx2_next.num_zero = (num2_next == 0);
        ctx2_next.h_neg    = num2_next[NUM_W-1] ^ (cfg.ny > 0);
        ctx2_next.ny_zero  = (cfg.ny == 0);
    end

    logic v2_reg;
    ctx_t ctx2_reg;
    logic signed [NUM_W-1:0] num2_reg;
    logic signed [DEN_W-1:0] den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx2_reg <= ctx2_next;
            num2_reg <= num2_next;
            den2_reg <= den2_next;
        end
    end

    // stage 3: magnitudes, shots scale the dividend to Q16.16
    logic [MAG_W-1:0] mag3;
    logic [DEN_W-1:0] dmag3;
    logic [X_W-1:0]   x3;

    always_comb begin
        mag3  = num2_reg[NUM_W-1] ? MAG_W'(-num2_reg) : MAG_W'(num2_reg);
        dmag3 = den2_reg[DEN_W-1] ? DEN_W'(-den2_reg) : DEN_W'(den2_reg);
        x3    = ctx2_reg.cmd ? X_W'(mag3) : (X_W'(mag3) << FRAC_W);
    end

    logic v3_reg;
    ctx_t ctx3_reg;
    logic [XH_W-1:0]  xh3_reg;
    logic [Q_W-1:0]   xl3_reg;
    logic [DEN_W-1:0] d3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx3_reg <= ctx2_reg;
            xh3_reg  <= x3[X_W-1:Q_W];
            xl3_reg  <= x3[Q_W-1:0];
            d3_reg   <= dmag3;
        end
    end

    // stage 4: quotient overflow check and divider seed
    logic v4_reg;
    ctx_t ctx4_reg;
    div_t div4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx4_reg     <= ctx3_reg;
            div4_reg.ovf <= (DEN_W'(xh3_reg) >= d3_reg);
            div4_reg.rem <= DEN_W'(xh3_reg);
            div4_reg.xl  <= xl3_reg;
            div4_reg.q   <= '0;
            div4_reg.d   <= d3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_ctx   = ctx4_reg;
    assign out_div   = div4_reg;

endmodule
`default_nettype wire

@@ rtl/rphit_div_stage.sv @@
`default_nettype none
module rphit_div_stage #(
    parameter int STEPS = rphit_pkg::DIV_BITS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  rphit_pkg::ctx_t in_ctx,
    input  rphit_pkg::div_t in_div,
    output logic            out_valid,
    output rphit_pkg::ctx_t out_ctx,
    output rphit_pkg::div_t out_div
);
    import rphit_pkg::*;

    div_t             w;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // restoring division, STEPS quotient bits per stage
    always_comb begin
        w     = in_div;
        trial = '0;
        qbit  = 1'b0;
        for (int i = 0; i < STEPS; i++) begin
            trial = {w.rem, w.xl[Q_W-1]};
            qbit  = (trial >= {1'b0, w.d});
            if (qbit) begin
                trial = trial - {1'b0, w.d};
            end
            w.rem = trial[DEN_W-1:0];
            w.xl  = {w.xl[Q_W-2:0], 1'b0};
            w.q   = {w.q[Q_W-2:0], qbit};
        end
    end

    logic v_reg;
    ctx_t ctx_reg;
    div_t div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (en)  v_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= in_ctx;
            div_reg <= w;
        end
    end

    assign out_valid = v_reg;
    assign out_ctx   = ctx_reg;
    assign out_div   = div_reg;

endmodule
`default_nettype wire

@@ rtl/rphit_back.sv @@
`default_nettype none
module rphit_back (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  rphit_pkg::cfg_t cfg,
    input  rphit_pkg::ctx_t in_ctx,
    input  rphit_pkg::div_t in_div,
    output logic            out_valid,
    output rphit_pkg::res_t out_res
);
    import rphit_pkg::*;

    // stage 1: distance, eligibility, height saturation
    logic                      sat1, mag_zero1, elig1_next;
    logic [Q_W-1:0]            dist_full;
    logic signed [EXT_W-1:0]   e1_next;
    logic signed [COORD_W-1:0] height1_next;

    always_comb begin
        sat1      = in_div.ovf | in_div.q[Q_W-1];
        mag_zero1 = !in_div.ovf && (in_div.q == '0);
        if (in_ctx.num_pos) begin
            dist_full = '0;
        end else if (sat1) begin
            dist_full = Q_W'(1) << (Q_W - 1);
        end else begin
            dist_full = in_div.q;
        end
        elig1_next = !in_ctx.cmd && in_ctx.t_neg && !(in_ctx.num_pos && !mag_zero1)
                     && (dist_full < {1'b0, in_ctx.best});
        e1_next = $signed({1'b0, dist_full}) - $signed({1'b0, EPS_Q16});
        priority if (in_ctx.ny_zero) begin
            if (in_ctx.num_pos)       height1_next = S32_MAX;
            else if (in_ctx.num_zero) height1_next = '0;
            else                      height1_next = S32_MIN;
        end else if (in_div.ovf) begin
            height1_next = in_ctx.h_neg ? S32_MIN : S32_MAX;
        end else if (!in_ctx.h_neg) begin
            height1_next = in_div.q[Q_W-1] ? S32_MAX : $signed(in_div.q);
        end else begin
            height1_next = (in_div.q[Q_W-1] && (in_div.q[Q_W-2:0] != '0))
                           ? S32_MIN : $signed(~in_div.q + Q_W'(1));
        end
    end

    logic v1_reg, elig1_reg;
    ctx_t ctx1_reg;
    logic [DIST_W-1:0]         dist1_reg;
    logic signed [EXT_W-1:0]   e1_reg;
    logic signed [COORD_W-1:0] height1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx1_reg    <= in_ctx;
            elig1_reg   <= elig1_next;
            dist1_reg   <= dist_full[DIST_W-1:0];
            e1_reg      <= e1_next;
            height1_reg <= height1_next;
        end
    end

    // stage 2: step back along the ray
    logic v2_reg, elig2_reg;
    ctx_t ctx2_reg;
    logic [DIST_W-1:0]         dist2_reg;
    logic signed [COORD_W-1:0] height2_reg;
    logic signed [EPROD_W-1:0] ex2_reg, ey2_reg, ez2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx2_reg    <= ctx1_reg;
            elig2_reg   <= elig1_reg;
            dist2_reg   <= dist1_reg;
            height2_reg <= height1_reg;
            ex2_reg     <= EPROD_W'(e1_reg) * EPROD_W'(ctx1_reg.dx);
            ey2_reg     <= EPROD_W'(e1_reg) * EPROD_W'(ctx1_reg.dy);
            ez2_reg     <= EPROD_W'(e1_reg) * EPROD_W'(ctx1_reg.dz);
        end
    end

    // stage 3: floor to Q16.16 and add the origin
    logic v3_reg, elig3_reg;
    ctx_t ctx3_reg;
    logic [DIST_W-1:0]         dist3_reg;
    logic signed [COORD_W-1:0] height3_reg;
    logic signed [FQ_W-1:0]    fx3_reg, fy3_reg, fz3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx3_reg    <= ctx2_reg;
            elig3_reg   <= elig2_reg;
            dist3_reg   <= dist2_reg;
            height3_reg <= height2_reg;
            fx3_reg     <= FQ_W'(ex2_reg >>> FRAC_W) + FQ_W'(ctx2_reg.px);
            fy3_reg     <= FQ_W'(ey2_reg >>> FRAC_W) + FQ_W'(ctx2_reg.py);
            fz3_reg     <= FQ_W'(ez2_reg >>> FRAC_W) + FQ_W'(ctx2_reg.pz);
        end
    end

    // stage 4: rectangle test and output register
    logic signed [CMP_W-1:0] dax, dcx, daz, dcz;
    logic in_x, in_z, hit4;
    res_t res_next;

    always_comb begin
        dax  = CMP_W'(fx3_reg) - CMP_W'(cfg.ax);
        dcx  = CMP_W'(fx3_reg) - CMP_W'(cfg.cx);
        daz  = CMP_W'(fz3_reg) - CMP_W'(cfg.az);
        dcz  = CMP_W'(fz3_reg) - CMP_W'(cfg.cz);
        in_x = dax[CMP_W-1] ^ dcx[CMP_W-1];
        in_z = daz[CMP_W-1] ^ dcz[CMP_W-1];
        hit4 = elig3_reg && in_x && in_z;
        res_next.hit    = hit4;
        res_next.hx     = hit4 ? sat32(fx3_reg) : '0;
        res_next.hy     = hit4 ? sat32(fy3_reg) : '0;
        res_next.hz     = hit4 ? sat32(fz3_reg) : '0;
        res_next.best   = hit4 ? dist3_reg : ctx3_reg.best;
        res_next.height = ctx3_reg.cmd ? height3_reg : '0;
    end

    logic v4_reg;
    res_t res4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) res4_reg <= res_next;
    end

    assign out_valid = v4_reg;
    assign out_res   = res4_reg;

endmodule
`default_nettype wire

@@ rtl/ray_plane_rect_hit_test.sv @@
// Ray test against one rectangular floor plane; coordinates in signed Q16.16.
// Configuration: write channel cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while the pipe is empty.
// Input: one item per s_ transfer; s_tuser carries the command (shot test
// or height query), s_tdata the origin, direction and best distance.
// Output: one result per input item, in order, on the m_ channel.
// The pipelined restoring divider between the front and back stages
// resolves DIV_BITS_PER_STAGE quotient bits in each stage.
// Throughput: one item per cycle while the output is not stalled; every
// stage is registered and fully pipelined, the divider included.
// Stall: while m_tvalid is high and m_tready low the whole pipe holds and
// s_tready drops; bubbles inside the pipe hold as well.
// Reset: aresetn low clears all valid bits and loads the register reset
// values (normal pointing along +y, everything else zero).
`default_nettype none
module ray_plane_rect_hit_test #(
    parameter int DIV_BITS_PER_STAGE = rphit_pkg::DIV_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rphit_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rphit_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, ray_dx, ray_dy, ray_dz, best_dist_in, zero pad
    input  wire logic [rphit_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  wire logic                              s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hit_x, hit_y, hit_z, best_dist_out, floor_height, zero pad
    output logic [rphit_pkg::M_TDATA_W-1:0]        m_tdata,
    // hit
    output logic                                   m_tuser
);
    import rphit_pkg::*;

    localparam int DIV_STAGES = Q_W / DIV_BITS_PER_STAGE;

    cfg_t cfg;
    logic en;
    ctx_t in_ctx;

    assign cfg_ready = 1'b1;

    rphit_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipe advances unless the output register holds an untaken result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        in_ctx      = '0;
        in_ctx.cmd  = s_tuser;
        in_ctx.px   = s_tdata[31:0];
        in_ctx.py   = s_tdata[63:32];
        in_ctx.pz   = s_tdata[95:64];
        in_ctx.dx   = s_tdata[127:96];
        in_ctx.dy   = s_tdata[159:128];
        in_ctx.dz   = s_tdata[191:160];
        in_ctx.best = s_tdata[222:192];
    end

    logic v_chain [DIV_STAGES+1];
    ctx_t ctx_chain [DIV_STAGES+1];
    div_t div_chain [DIV_STAGES+1];

    rphit_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid & s_tready),
        .cfg       (cfg),
        .in_ctx    (in_ctx),
        .out_valid (v_chain[0]),
        .out_ctx   (ctx_chain[0]),
        .out_div   (div_chain[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        rphit_div_stage #(
            .STEPS (DIV_BITS_PER_STAGE)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_chain[g]),
            .in_ctx    (ctx_chain[g]),
            .in_div    (div_chain[g]),
            .out_valid (v_chain[g+1]),
            .out_ctx   (ctx_chain[g+1]),
            .out_div   (div_chain[g+1])
        );
    end

    res_t res;

    rphit_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_chain[DIV_STAGES]),
        .cfg       (cfg),
        .in_ctx    (ctx_chain[DIV_STAGES]),
        .in_div    (div_chain[DIV_STAGES]),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tuser = res.hit;
    assign m_tdata = {1'b0, res.height, res.best, res.hz, res.hy, res.hx};

endmodule
`default_nettype wire

@@ rtl/rphit_chk.sv @@
`default_nettype none
`include "ray_plane_rect_hit_test_defines.svh"
module rphit_chk (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [rphit_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                             m_tuser
);
    import rphit_pkg::*;

    // a stalled result holds
    `RPHIT_ASSERT_NEXT(a_out_hold, aclk, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), aresetn)

    // a miss or height query reports no hit point
    `RPHIT_ASSERT_IMPLY(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[95:0] == '0)

    // a hit is a shot, so its height field is clear
    `RPHIT_ASSERT_IMPLY(a_hit_no_height, aclk, aresetn, m_tvalid && m_tuser, m_tdata[158:127] == '0)

    // reset empties the pipe
    `RPHIT_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind ray_plane_rect_hit_test rphit_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
    import rphit_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    localparam int LATENCY = 24;
    localparam logic CMD_SHOT = 1'b0;
    localparam logic CMD_HEIGHT = 1'b1;

    ray_plane_rect_hit_test u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // plane settings as the predictor sees them
    logic signed [17:0] pl_nx = 18'sd65536 - 18'sd65536, pl_ny = 18'sd65536, pl_nz = '0;
    logic signed [31:0] pl_off = '0, pl_ax = '0, pl_az = '0, pl_cx = '0, pl_cz = '0;

    res_t hit_results_q[$];
    int errors = 0;
    int hold_cycles = 0;

    function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Expected result of one item, computed with wide exact arithmetic
    function automatic res_t predict_hit(input logic cmd, input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz,
            input logic signed [31:0] dx, input logic signed [31:0] dy,
            input logic signed [31:0] dz, input logic [30:0] best);
        res_t r;
        logic signed [63:0] nx, ny, nz, t, num, e, fx, fy, fz, ht;
        logic [63:0] mag, dist_v, q;
        logic [127:0] wq;
        bit inx, inz;
        nx = pl_nx; ny = pl_ny; nz = pl_nz;
        r = '0;
        r.best = best;
        if (cmd == CMD_HEIGHT) begin
            num = nx * px + nz * pz - (64'(pl_off) <<< 16);
            if (ny != 0) ht = clamp32(num / (-ny));
            else ht = (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 0);
            r.height = ht[31:0];
        end else begin
            t = dx * nx + dy * ny + dz * nz;
            num = (64'(pl_off) <<< 16) - (px * nx + py * ny + pz * nz);
            if (t < 0) begin
                mag = (num >= 0) ? num : -num;
                // quotient in Q16.16 at full width, then saturated
                wq = {mag, 16'd0} / {64'd0, 64'(-t)};
                q = (wq >= 128'h8000_0000) ? 64'h8000_0000 : wq[63:0];
                dist_v = (num > 0) ? 0 : q;
                if (!(num > 0 && q != 0) && dist_v < {33'd0, best}) begin
                    e = $signed(dist_v) - 655;
                    fx = floor16(e * dx) + px;
                    fy = floor16(e * dy) + py;
                    fz = floor16(e * dz) + pz;
                    inx = ((fx - pl_ax) >= 0) != ((fx - pl_cx) >= 0);
                    inz = ((fz - pl_az) >= 0) != ((fz - pl_cz) >= 0);
                    if (inx && inz) begin
                        r.hit = 1'b1;
                        r.hx = clamp32(fx);
                        r.hy = clamp32(fy);
                        r.hz = clamp32(fz);
                        r.best = dist_v[30:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one item and record its expected result
    task automatic send_item(input logic cmd, input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz,
            input logic signed [31:0] dx, input logic signed [31:0] dy,
            input logic signed [31:0] dz, input logic [30:0] best, input bit nogap);
        int g;
        g = nogap ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, best, dz, dy, dx, pz, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hit_results_q.push_back(predict_hit(cmd, px, py, pz, dx, dy, dz, best));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (hit_results_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_NORMAL_X:     pl_nx = val[17:0];
            REG_NORMAL_Y:     pl_ny = val[17:0];
            REG_NORMAL_Z:     pl_nz = val[17:0];
            REG_PLANE_OFFSET: pl_off = val;
            REG_CORNER_A_X:   pl_ax = val;
            REG_CORNER_A_Z:   pl_az = val;
            REG_CORNER_C_X:   pl_cx = val;
            default:          pl_cz = val;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_plane(input logic [17:0] nx, input logic [17:0] ny,
            input logic [17:0] nz, input logic [31:0] off, input logic [31:0] ax,
            input logic [31:0] az, input logic [31:0] cx, input logic [31:0] cz);
        write_reg(REG_NORMAL_X, {{14{nx[17]}}, nx});
        write_reg(REG_NORMAL_Y, {{14{ny[17]}}, ny});
        write_reg(REG_NORMAL_Z, {{14{nz[17]}}, nz});
        write_reg(REG_PLANE_OFFSET, off);
        write_reg(REG_CORNER_A_X, ax);
        write_reg(REG_CORNER_A_Z, az);
        write_reg(REG_CORNER_C_X, cx);
        write_reg(REG_CORNER_C_Z, cz);
        cfg_valid <= 1'b0;
    endtask

    // a well-aimed shot: origin above the floor, heading down into the rectangle
    task automatic send_aimed_shot();
        logic signed [31:0] px, pz;
        px = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        pz = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        send_item(CMD_SHOT, px, $signed($urandom_range(1 << 16, 30 << 16)), pz,
            $signed($urandom_range(0, 1 << 16)) - (1 <<< 15),
            -$signed($urandom_range(1 << 10, 1 << 17)),
            $signed($urandom_range(0, 1 << 16)) - (1 <<< 15),
            ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'h7FFF_FFFF, 1'b0);
    endtask

    task automatic send_noise();
        send_item($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 31'($urandom), 1'b0);
    endtask

    task automatic test_reset_plane();
        send_item(CMD_HEIGHT, 32'sd65536, 32'sd0, -32'sd65536, 0, 0, 0, 31'd5, 1'b0);
        send_item(CMD_SHOT, 0, 32'sd65536, 0, 0, -32'sd65536, 0, 31'h7FFF_FFFF, 1'b0);
        drain();
    endtask

    task automatic test_directed();
        // floor y = 0, square of side 20 centred on the origin
        set_plane(18'sd0, 18'sd65536, 18'sd0, 32'sd0, -32'sd655360, -32'sd655360,
            32'sd655360, 32'sd655360);
        // straight down, a hit
        send_item(CMD_SHOT, 32'sd65536, 32'sd327680, 32'sd65536, 0, -32'sd65536, 0,
            31'h7FFF_FFFF, 1'b0);
        // same shot, hidden by a nearer best
        send_item(CMD_SHOT, 32'sd65536, 32'sd327680, 32'sd65536, 0, -32'sd65536, 0,
            31'd65536, 1'b0);
        // parallel and facing away
        send_item(CMD_SHOT, 0, 32'sd65536, 0, 32'sd65536, 0, 0, 31'h7FFF_FFFF, 1'b0);
        send_item(CMD_SHOT, 0, 32'sd65536, 0, 0, 32'sd65536, 0, 31'h7FFF_FFFF, 1'b0);
        // origin just below the plane: tiny negative dist truncates to zero
        send_item(CMD_SHOT, 0, -32'sd1, 0, 0, -32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF, 1'b0);
        // behind the ray
        send_item(CMD_SHOT, 0, -32'sd655360, 0, 0, -32'sd65536, 0, 31'h7FFF_FFFF, 1'b0);
        // outside the rectangle
        send_item(CMD_SHOT, 32'sd6553600, 32'sd65536, 0, 0, -32'sd65536, 0,
            31'h7FFF_FFFF, 1'b0);
        // saturated distance, extreme fields
        send_item(CMD_SHOT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
            -32'sd1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_item(CMD_SHOT, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 31'd0, 1'b0);
        send_item(CMD_HEIGHT, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0, 31'd0, 1'b0);
        drain();
        // tilted plane, small normal y: height saturates
        set_plane(18'sh20000, 18'sd1, 18'sh1FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(CMD_HEIGHT, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 0, 0, 0, 31'd1, 1'b0);
        send_item(CMD_HEIGHT, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 0, 0, 31'd1, 1'b0);
        send_item(CMD_SHOT, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b0);
        drain();
        // vertical plane: height sign only
        set_plane(18'sd65536, 18'sd0, 18'sd0, 32'sd65536, 0, 0, 0, 0);
        send_item(CMD_HEIGHT, 32'sd655360, 0, 0, 0, 0, 0, 31'd0, 1'b0);
        send_item(CMD_HEIGHT, -32'sd655360, 0, 0, 0, 0, 0, 31'd0, 1'b0);
        send_item(CMD_HEIGHT, 32'sd65536, 0, 0, 0, 0, 0, 31'd0, 1'b0);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7) send_aimed_shot();
            else send_noise();
        end
        drain();
    endtask

    task automatic random_plane();
        logic signed [17:0] ny;
        ny = ($urandom_range(0, 4) == 0) ? 18'($urandom) :
             18'($signed($urandom_range(1 << 14, 1 << 16)));
        set_plane(18'($signed($urandom_range(0, 1 << 15)) - (1 << 14)), ny,
            18'($signed($urandom_range(0, 1 << 15)) - (1 << 14)),
            $signed($urandom_range(0, 4 << 16)) - (2 << 16),
            -$signed($urandom_range(0, 20 << 16)), $signed($urandom_range(0, 20 << 16)),
            $signed($urandom_range(0, 20 << 16)), -$signed($urandom_range(0, 20 << 16)));
    endtask

    // receiver stalls long while items keep coming, so the pipe fills
    task automatic test_backpressure();
        // set the hold away from the receiver's falling edge
        @(posedge aclk);
        hold_cycles = 80;
        @(negedge aclk);
        for (int i = 0; i < 60; i++) send_item($urandom_range(0, 1), $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, 31'($urandom), 1'b1);
        drain();
    endtask

    // receiver: random gaps, random long holds, or a counted long hold when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                        (($urandom_range(0, 199) == 0) ? 1'b0 : 1'b1);
            if ($urandom_range(0, 299) == 0) hold_cycles <= $urandom_range(10, 40);
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        res_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser;
            got.hx = m_tdata[31:0];
            got.hy = m_tdata[63:32];
            got.hz = m_tdata[95:64];
            got.best = m_tdata[126:96];
            got.height = m_tdata[158:127];
            if (hit_results_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                exp_r = hit_results_q.pop_front();
                if (got.hit !== exp_r.hit) begin
                    $error("hit: expected %0d actual %0d", exp_r.hit, got.hit); errors++;
                end
                if (got.hx !== exp_r.hx) begin
                    $error("hit_x: expected %0d actual %0d", exp_r.hx, got.hx); errors++;
                end
                if (got.hy !== exp_r.hy) begin
                    $error("hit_y: expected %0d actual %0d", exp_r.hy, got.hy); errors++;
                end
                if (got.hz !== exp_r.hz) begin
                    $error("hit_z: expected %0d actual %0d", exp_r.hz, got.hz); errors++;
                end
                if (got.best !== exp_r.best) begin
                    $error("best_dist_out: expected %0d actual %0d", exp_r.best, got.best);
                    errors++;
                end
                if (got.height !== exp_r.height) begin
                    $error("floor_height: expected %0d actual %0d", exp_r.height,
                        got.height);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_plane();
        test_directed();
        test_backpressure();
        for (int p = 0; p < 5; p++) begin
            random_plane();
            test_random(200);
        end
        if (errors == 0 && hit_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
